>>> design/crml_pkg.sv
package crml_pkg;

   // item modes
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // request transaction
   typedef struct packed {
      logic        mode;
      logic [5:0]  entry_index;
      logic [15:0] crate_id;
      logic [15:0] module_address;
      logic [15:0] elec_channel;
      logic [15:0] first_elec_channel;
      logic [15:0] elec_channel_count;
      logic [15:0] channel_step;
      logic [15:0] first_det_channel;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic        found;
      logic [15:0] det_channel;
      logic [5:0]  matched_entry;
   } rsp_payload_type;

   // one table word: key, covered range, step and detector base
   typedef struct packed {
      logic [15:0] crate_id;
      logic [15:0] module_address;
      logic [15:0] first;
      logic [15:0] count;
      logic [15:0] step;
      logic [15:0] base;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

>>> design/crml_if.sv
// request channel
interface crml_req_if;
   logic                     valid;
   logic                     ready;
   crml_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// response channel
interface crml_rsp_if;
   logic                     valid;
   logic                     ready;
   crml_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/channel_range_map_lookup.sv
// channel    dir  handshake      payload
// req_ch     in   valid/ready    load or lookup transaction
// rsp_ch     out  valid/ready    found, det_channel, matched_entry
// csr_*      in   write enable   entries_in_use (7 bits)
//
// A load gives no response. A lookup scans the table through the memory's
// single read port, one entry per cycle while no candidate is being checked,
// and each entry whose key and range match pauses the scan for the radix-2
// divider that checks the step.
// Reset clears control state only; the table is undefined until loaded.
// A finished response waits in the output register; a new transaction is
// taken as soon as the result has moved into it.
module channel_range_map_lookup #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   crml_req_if.sink         req_ch,
   crml_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data
);
   import crml_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;

   // table memory, one write and one registered read port
   entry_type             mem [MAX_ENTRIES];
   entry_type             rdata_ff;
   logic                  mem_rd_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   entry_type             mem_wdata;

   // control state
   state_type             state_ff, state_in;
   logic [6:0]            entries_ff, entries_in;
   logic                  vld_ff, vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      addr_ff, addr_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      cand_ff, cand_in;
   logic [15:0]           crate_ff, crate_in;
   logic [15:0]           maddr_ff, maddr_in;
   logic [15:0]           ch_ff, ch_in;
   logic [16:0]           rem_ff, rem_in;
   logic [15:0]           quo_ff, quo_in;
   logic [15:0]           step_ff, step_in;
   logic [15:0]           base_ff, base_in;
   logic [3:0]            div_cnt_ff, div_cnt_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // memory access
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         rdata_ff <= mem[mem_rd_addr];
      end
   end

   // next state, table access, divider step
   always_comb begin
      logic [LIM_W-1:0] cfg_ext;
      logic             key_hit;
      logic             range_hit;
      logic [16:0]      shifted;
      logic [16:0]      diff;
      logic             out_free;

      state_in     = state_ff;
      entries_in   = entries_ff;
      vld_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      limit_in     = limit_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      cand_in      = cand_ff;
      crate_in     = crate_ff;
      maddr_in     = maddr_ff;
      ch_in        = ch_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      div_cnt_in   = div_cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;

      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff[IDX_W-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = IDX_W'(req_ch.payload.entry_index);
      mem_wdata.crate_id       = req_ch.payload.crate_id;
      mem_wdata.module_address = req_ch.payload.module_address;
      mem_wdata.first          = req_ch.payload.first_elec_channel;
      mem_wdata.count          = req_ch.payload.elec_channel_count;
      mem_wdata.step           = (req_ch.payload.channel_step == 16'd0) ?
                                 16'd1 : req_ch.payload.channel_step;
      mem_wdata.base           = req_ch.payload.first_det_channel;

      req_ch.ready = (state_ff == ST_IDLE);
      out_free     = !rsp_valid_ff || rsp_ch.ready;

      // config register, saturated to the table depth at lookup start
      if (csr_wr_en) begin
         entries_in = csr_wr_data;
      end
      cfg_ext = LIM_W'(entries_ff);

      // candidate test on the entry read last cycle
      key_hit   = (rdata_ff.crate_id == crate_ff) && (rdata_ff.module_address == maddr_ff);
      range_hit = (ch_ff >= rdata_ff.first) &&
                  ({1'b0, ch_ff} < ({1'b0, rdata_ff.first} + {1'b0, rdata_ff.count}));

      // restoring divider step
      shifted = {rem_ff[15:0], quo_ff[15]};
      diff    = shifted - {1'b0, step_ff};

      // response register drains independently
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.payload.mode == MODE_LOAD) begin
                  mem_wr_en = (32'(req_ch.payload.entry_index) < MAX_ENTRIES);
               end else begin
                  crate_in = req_ch.payload.crate_id;
                  maddr_in = req_ch.payload.module_address;
                  ch_in    = req_ch.payload.elec_channel;
                  addr_in  = '0;
                  if (32'(cfg_ext) > MAX_ENTRIES) begin
                     limit_in = CNT_W'(MAX_ENTRIES);
                  end else begin
                     limit_in = CNT_W'(cfg_ext);
                  end
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue the next read
            if (addr_ff < limit_ff) begin
               mem_rd_en = 1'b1;
               vld_in    = 1'b1;
               idx_in    = addr_ff[IDX_W-1:0];
               addr_in   = addr_ff + CNT_W'(1);
            end
            // evaluate the one in flight
            if (vld_ff && key_hit && range_hit) begin
               vld_in     = 1'b0;
               addr_in    = CNT_W'(idx_ff) + CNT_W'(1);
               cand_in    = idx_ff;
               rem_in     = '0;
               quo_in     = ch_ff - rdata_ff.first;
               step_in    = rdata_ff.step;
               base_in    = rdata_ff.base;
               div_cnt_in = 4'd15;
               state_in   = ST_DIV;
            end else if (!vld_ff && !(addr_ff < limit_ff)) begin
               res_in.found         = 1'b0;
               res_in.det_channel   = '0;
               res_in.matched_entry = '0;
               state_in             = ST_DONE;
            end
         end

         ST_DIV: begin
            if (!diff[16]) begin
               rem_in = diff;
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 4'd1;
            if (div_cnt_ff == 4'd0) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (rem_ff == 17'd0) begin
               res_in.found         = 1'b1;
               res_in.det_channel   = base_ff + quo_ff;
               res_in.matched_entry = 6'(cand_ff);
               state_in             = ST_DONE;
            end else begin
               // off-grid channel: resume after the candidate
               state_in = ST_SCAN;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      limit_ff   <= limit_in;
      addr_ff    <= addr_in;
      idx_ff     <= idx_in;
      cand_ff    <= cand_in;
      crate_ff   <= crate_in;
      maddr_ff   <= maddr_in;
      ch_ff      <= ch_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      base_ff    <= base_in;
      div_cnt_ff <= div_cnt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule
